// ===== rtl/core/frs_pkg.sv =====
// ----------------------------------------------------------------------------
// frs_pkg
// Shared widths, request and status codes, sequencer states and the control
// word that travels along the cell chain of the roulette selector.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int FIT_W      = 48;              // signed fitness field
   localparam int SUM_W      = 56;              // prefix sums and total
   localparam int WT_W       = 48;              // single entry weight
   localparam int DRAW_W     = 16;              // draw fraction, Q0.16
   localparam int IDX_W      = 7;               // selected index field
   localparam int STATUS_W   = 2;
   localparam int REQ_W      = 2;
   localparam int MUL_LO_W   = 32;              // low slice of total per multiply
   localparam int MUL_HI_W   = SUM_W - MUL_LO_W;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_DRAW  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_TARGET,
      ST_CHAIN,
      ST_DONE
   } state_type;

   // Control word of a chain token: wr marks a store, hit marks that the
   // token has been consumed (stored or matched) by an earlier cell.
   typedef struct packed {
      logic valid;
      logic wr;
      logic hit;
   } tok_ctl_type;

endpackage

// ===== rtl/core/frs_recip_div.sv =====
// ----------------------------------------------------------------------------
// frs_recip_div
// Fitness to weight mapping: 1+f for positive f, otherwise 1/(1-f) by a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frs_recip_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [frs_pkg::FIT_W-1:0]  fitness,
   output logic                              done,
   output logic        [frs_pkg::WT_W-1:0]   weight
);

   localparam int REM_W  = 2 * FRAC_BITS + 1;
   localparam int CMP_W  = (REM_W > frs_pkg::WT_W) ? REM_W : frs_pkg::WT_W;
   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   logic                      busy_ff,   busy_in;
   logic                      done_ff,   done_in;
   logic [CMP_W-1:0]          rem_ff,    rem_in;
   logic [CMP_W-1:0]          den_ff,    den_in;
   logic [QUO_W-1:0]          quo_ff,    quo_in;
   logic [STEP_W-1:0]         step_ff,   step_in;
   logic [frs_pkg::WT_W-1:0]  weight_ff, weight_in;

   logic [frs_pkg::WT_W-1:0]  one_w;
   logic [frs_pkg::WT_W-1:0]  mag_w;
   logic                      positive;
   logic                      rem_ge;
   logic [CMP_W-1:0]          rem_sub;
   logic [QUO_W-1:0]          quo_next;

   assign one_w    = {{(frs_pkg::WT_W-1){1'b0}}, 1'b1} << FRAC_BITS;
   assign mag_w    = frs_pkg::WT_W'($unsigned(-fitness));
   assign positive = !fitness[frs_pkg::FIT_W-1] && (fitness != '0);
   assign rem_ge   = (rem_ff >= den_ff);
   assign rem_sub  = rem_ge ? (rem_ff - den_ff) : rem_ff;
   assign quo_next = {quo_ff[QUO_W-2:0], rem_ge};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      weight_in = weight_ff;
      if (start) begin
         if (positive) begin
            weight_in = frs_pkg::WT_W'($unsigned(fitness)) + one_w;
            done_in   = 1'b1;
         end else begin
            // numerator 2^(2F): start with its upper part 2^F, bring down F zeros
            busy_in = 1'b1;
            rem_in  = {{(CMP_W-1){1'b0}}, 1'b1} << FRAC_BITS;
            den_in  = CMP_W'(mag_w + one_w);
            quo_in  = '0;
            step_in = STEP_W'(FRAC_BITS);
         end
      end else if (busy_ff) begin
         rem_in  = rem_sub << 1;
         quo_in  = quo_next;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            weight_in = frs_pkg::WT_W'(quo_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      weight_ff <= weight_in;
   end

   assign done   = done_ff;
   assign weight = weight_ff;

endmodule

// ===== rtl/core/frs_cell.sv =====
// ----------------------------------------------------------------------------
// frs_cell
// One table entry. Holds a prefix sum and passes a token to its neighbour
// every cycle; a store token lands where its countdown reaches zero, a
// search token stops at the first stored prefix that reaches its target.
// ----------------------------------------------------------------------------
module frs_cell #(
   parameter int CNT_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  frs_pkg::tok_ctl_type        in_ctl,
   input  logic [frs_pkg::SUM_W-1:0]   in_value,
   input  logic [CNT_W-1:0]            in_left,
   output frs_pkg::tok_ctl_type        out_ctl,
   output logic [frs_pkg::SUM_W-1:0]   out_value,
   output logic [CNT_W-1:0]            out_left
);

   logic [frs_pkg::SUM_W-1:0]  prefix_ff, prefix_in;
   frs_pkg::tok_ctl_type       ctl_ff,    ctl_in;
   logic [frs_pkg::SUM_W-1:0]  value_ff;
   logic [CNT_W-1:0]           left_ff,   left_in;

   logic active;
   logic left_zero;
   logic capture;
   logic match;

   assign active    = in_ctl.valid && !in_ctl.hit;
   assign left_zero = (in_left == '0);
   assign capture   = active && in_ctl.wr && left_zero;
   assign match     = active && !in_ctl.wr && !left_zero && (prefix_ff >= in_value);

   always_comb begin
      ctl_in     = in_ctl;
      ctl_in.hit = in_ctl.hit || capture || match;
      // count down only over stored entries; hold the count on a match
      left_in    = (active && !left_zero && !match) ? (in_left - CNT_W'(1)) : in_left;
      prefix_in  = capture ? in_value : prefix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
      value_ff  <= in_value;
      left_ff   <= left_in;
   end

   assign out_ctl   = ctl_ff;
   assign out_value = value_ff;
   assign out_left  = left_ff;

endmodule

// ===== rtl/core/fitness_roulette_selector_top.sv =====
// ----------------------------------------------------------------------------
// fitness_roulette_selector_top
// Fitness-proportional (roulette wheel) selection over a table of prefix
// sums held in a chain of cells, with an iterative reciprocal weight unit.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake              Payload
//  req_      in    req_valid/req_ready    req_type, req_fitness_value,
//                                         req_draw_fraction
//  rsp_      out   rsp_valid/rsp_ready    rsp_selected_index, rsp_status
//
//  One word in, one word out; one request is worked on at a time.
//  Draw: the target is formed from a 16 x 32 and a 16 x 24 partial product
//  in the states MUL_LO, MUL_HI and TARGET, then the search token walks
//  the chain of cells.
//  Load: a non-positive fitness goes through the reciprocal divider (one
//  quotient bit per cycle), a positive one is mapped by a single add; the
//  store token walks the whole chain too.
//  Clear, unused code, draw on an empty table, load on a full table: these go from idle straight to the done state.
//  Reset (synchronous) empties the table at once; no clearing pass is run.
//  A finished result waits in the output register while the next word is
//  taken; a stalled output only holds the sequencer in its final state.
//
module fitness_roulette_selector_top #(
   parameter int MAX_ENTRIES = 128,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic        [frs_pkg::REQ_W-1:0]    req_type,
   input  logic signed [frs_pkg::FIT_W-1:0]    req_fitness_value,
   input  logic        [frs_pkg::DRAW_W-1:0]   req_draw_fraction,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [frs_pkg::IDX_W-1:0]    rsp_selected_index,
   output logic        [frs_pkg::STATUS_W-1:0] rsp_status
);

   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int PROD_LO = frs_pkg::DRAW_W + frs_pkg::MUL_LO_W;
   localparam int PROD_HI = frs_pkg::DRAW_W + frs_pkg::MUL_HI_W;
   localparam int SUM_W   = frs_pkg::SUM_W;

   // sequencer
   frs_pkg::state_type          state_ff, state_in;
   frs_pkg::req_code_type       req_code;
   logic                        accept;

   // table bookkeeping
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [SUM_W-1:0]            total_ff, total_in;

   // draw target arithmetic
   logic [frs_pkg::DRAW_W-1:0]  frac_ff,    frac_in;
   logic [PROD_LO-1:0]          prod_lo_ff, prod_lo_in;
   logic [PROD_HI-1:0]          prod_hi_ff, prod_hi_in;
   logic [frs_pkg::MUL_LO_W:0]  lo_ceil;
   logic [SUM_W-1:0]            target;

   // weight unit
   logic                        div_start;
   logic                        div_done;
   logic [frs_pkg::WT_W-1:0]    div_weight;
   logic [SUM_W:0]              sum_wide;
   logic [SUM_W-1:0]            sum_sat;

   // staged result and output register
   logic [CNT_W-1:0]            res_idx_ff,     res_idx_in;
   frs_pkg::status_type         res_status_ff,  res_status_in;
   logic                        rsp_valid_ff,   rsp_valid_in;
   logic [frs_pkg::IDX_W-1:0]   rsp_idx_ff,     rsp_idx_in;
   frs_pkg::status_type         rsp_status_ff,  rsp_status_in;
   logic                        out_free;

   // cell chain
   frs_pkg::tok_ctl_type        chain_ctl   [0:MAX_ENTRIES];
   logic [SUM_W-1:0]            chain_value [0:MAX_ENTRIES];
   logic [CNT_W-1:0]            chain_left  [0:MAX_ENTRIES];
   logic                        inject;
   frs_pkg::tok_ctl_type        exit_ctl;
   logic [CNT_W-1:0]            exit_left;

   assign req_code = frs_pkg::req_code_type'(req_type);
   assign accept   = req_valid && (state_ff == frs_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Weight unit: started on an accepted load that has room in the table
   // ---------------------------------------------------------------------
   assign div_start = accept && (req_code == frs_pkg::REQ_LOAD)
                      && (count_ff != CNT_W'(MAX_ENTRIES));

   frs_recip_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_recip_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .fitness (req_fitness_value),
      .done    (div_done),
      .weight  (div_weight)
   );

   // saturating running total
   assign sum_wide = {1'b0, total_ff} + (SUM_W + 1)'(div_weight);
   assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   // target = ceil(x * total / 2^16), from the two partial products
   assign lo_ceil = {1'b0, prod_lo_ff[PROD_LO-1:frs_pkg::DRAW_W]}
                    + (frs_pkg::MUL_LO_W + 1)'(|prod_lo_ff[frs_pkg::DRAW_W-1:0]);
   assign target  = SUM_W'({prod_hi_ff, {(frs_pkg::MUL_LO_W - frs_pkg::DRAW_W){1'b0}}})
                    + SUM_W'(lo_ceil);

   // ---------------------------------------------------------------------
   // Chain of cells: one token enters at cell 0 and leaves after the last
   // ---------------------------------------------------------------------
   assign inject = ((state_ff == frs_pkg::ST_DIV) && div_done)
                   || (state_ff == frs_pkg::ST_TARGET);

   always_comb begin
      chain_ctl[0].valid = inject;
      chain_ctl[0].wr    = (state_ff == frs_pkg::ST_DIV);
      chain_ctl[0].hit   = 1'b0;
      chain_value[0]     = (state_ff == frs_pkg::ST_DIV) ? sum_sat : target;
      // a store lands in the cell numbered by the old count
      chain_left[0]      = count_ff;
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      frs_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (chain_ctl[g]),
         .in_value  (chain_value[g]),
         .in_left   (chain_left[g]),
         .out_ctl   (chain_ctl[g+1]),
         .out_value (chain_value[g+1]),
         .out_left  (chain_left[g+1])
      );
   end

   assign exit_ctl  = chain_ctl[MAX_ENTRIES];
   assign exit_left = chain_left[MAX_ENTRIES];

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frs_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_code)
                  frs_pkg::REQ_LOAD: begin
                     state_in = (count_ff == CNT_W'(MAX_ENTRIES)) ?
                                frs_pkg::ST_DONE : frs_pkg::ST_DIV;
                  end
                  frs_pkg::REQ_DRAW: begin
                     state_in = (count_ff == '0) ? frs_pkg::ST_DONE : frs_pkg::ST_MUL_LO;
                  end
                  default: begin
                     state_in = frs_pkg::ST_DONE;
                  end
               endcase
            end
         end
         frs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = frs_pkg::ST_CHAIN;
            end
         end
         frs_pkg::ST_MUL_LO: begin
            state_in = frs_pkg::ST_MUL_HI;
         end
         frs_pkg::ST_MUL_HI: begin
            state_in = frs_pkg::ST_TARGET;
         end
         frs_pkg::ST_TARGET: begin
            state_in = frs_pkg::ST_CHAIN;
         end
         frs_pkg::ST_CHAIN: begin
            if (exit_ctl.valid) begin
               state_in = frs_pkg::ST_DONE;
            end
         end
         frs_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = frs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frs_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_ready = (state_ff == frs_pkg::ST_IDLE);
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_comb begin
      count_in      = count_ff;
      total_in      = total_ff;
      frac_in       = frac_ff;
      prod_lo_in    = prod_lo_ff;
      prod_hi_in    = prod_hi_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         frs_pkg::ST_IDLE: begin
            if (accept) begin
               frac_in       = req_draw_fraction;
               res_idx_in    = '0;
               res_status_in = frs_pkg::STATUS_DONE;
               case (req_code)
                  frs_pkg::REQ_LOAD: begin
                     if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                        res_status_in = frs_pkg::STATUS_FULL;   // drop the entry
                     end
                  end
                  frs_pkg::REQ_DRAW: begin
                     if (count_ff == '0) begin
                        res_status_in = frs_pkg::STATUS_EMPTY;
                     end
                  end
                  frs_pkg::REQ_CLEAR: begin
                     // stale cells are simply overwritten by later loads
                     count_in = '0;
                     total_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         frs_pkg::ST_DIV: begin
            if (div_done) begin
               total_in = sum_sat;
               count_in = count_ff + CNT_W'(1);
            end
         end
         frs_pkg::ST_MUL_LO: begin
            prod_lo_in = PROD_LO'(frac_ff) * PROD_LO'(total_ff[frs_pkg::MUL_LO_W-1:0]);
         end
         frs_pkg::ST_MUL_HI: begin
            prod_hi_in = PROD_HI'(frac_ff) * PROD_HI'(total_ff[SUM_W-1:frs_pkg::MUL_LO_W]);
         end
         frs_pkg::ST_CHAIN: begin
            if (exit_ctl.valid && !exit_ctl.wr) begin
               // the countdown freezes at the matching cell: index = count - left
               res_idx_in = exit_ctl.hit ? (count_ff - exit_left) : (count_ff - CNT_W'(1));
            end
         end
         frs_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = frs_pkg::IDX_W'(res_idx_ff);
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frs_pkg::ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff       <= frac_in;
      prod_lo_ff    <= prod_lo_in;
      prod_hi_ff    <= prod_hi_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_idx_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== rtl/core/frs_checker.sv =====
// ----------------------------------------------------------------------------
// frs_checker
// Port-level checks on the roulette selector, bound to the top level.
// ----------------------------------------------------------------------------
module frs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic        [frs_pkg::REQ_W-1:0]    req_type,
   input logic signed [frs_pkg::FIT_W-1:0]    req_fitness_value,
   input logic        [frs_pkg::DRAW_W-1:0]   req_draw_fraction,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic        [frs_pkg::IDX_W-1:0]    rsp_selected_index,
   input logic        [frs_pkg::STATUS_W-1:0] rsp_status
);

   // a waiting request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_type)
                                  && $stable(req_fitness_value)
                                  && $stable(req_draw_fraction))
      else $error("request word changed while waiting");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_selected_index)
                                  && $stable(rsp_status))
      else $error("result word changed while stalled");

   // one request in flight: ready drops after every accepted word
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while a request is in flight");

   // error results carry index zero
   a_err_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != frs_pkg::STATUS_DONE) |-> rsp_selected_index == '0)
      else $error("error result with non-zero index");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fitness_roulette_selector_top frs_checker u_frs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_type           (req_type),
   .req_fitness_value  (req_fitness_value),
   .req_draw_fraction  (req_draw_fraction),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_selected_index (rsp_selected_index),
   .rsp_status         (rsp_status)
);
